FILE: rtl/sdsch_pkg.sv
// Package for the SCAN disk scheduler: widths, register map, list codes.
// No dependencies; imported by every module of the block but sdsch_ram.
`timescale 1ns / 1ps
`default_nettype none

package sdsch_pkg;

  localparam int SDSCH_MAX_REQ = 32;       // default batch capacity
  localparam int TRACK_W       = 16;       // track / distance width
  localparam int SEEK_W        = 17;       // running seek total width
  localparam int APB_AW        = 3;        // two 32-bit registers
  localparam int APB_DW        = 32;

  // Register map (index = paddr[2])
  localparam logic REG_DISK_END   = 1'b0;
  localparam logic REG_START_HEAD = 1'b1;

  localparam logic [TRACK_W-1:0] DISK_END_RST   = 16'd199;
  localparam logic [TRACK_W-1:0] START_HEAD_RST = 16'd0;

  // List select bit, top bit of the RAM address
  localparam logic LIST_DN = 1'b0;
  localparam logic LIST_UP = 1'b1;

endpackage

`default_nettype wire

FILE: rtl/sdsch_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sdsch_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/sdsch_alu.sv
// Shared compare / absolute-difference unit of the scheduler.
// Depends on sdsch_pkg (track width).
`timescale 1ns / 1ps
`default_nettype none

module sdsch_alu
  import sdsch_pkg::*;
(
  input  wire logic [TRACK_W-1:0] op_a_i,
  input  wire logic [TRACK_W-1:0] op_b_i,
  output      logic               lt_o,     // op_a < op_b
  output      logic [TRACK_W-1:0] abs_o     // |op_a - op_b|
);

  logic [TRACK_W:0] diff;

  // one subtractor: borrow gives the compare, negate gives the magnitude
  assign diff  = {1'b0, op_a_i} - {1'b0, op_b_i};
  assign lt_o  = diff[TRACK_W];
  assign abs_o = diff[TRACK_W] ? (TRACK_W'(0) - diff[TRACK_W-1:0]) : diff[TRACK_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/scan_disk_scheduler_unit.sv
// A request whose list is empty is written straight from S_IDLE; one that meets a full batch
// is dropped there. Otherwise S_INS shifts the entries that sort after it one place each, and the
// request is written in S_INS or S_PUT. The last request then emits its schedule: S_UP_RD/S_UP_OUT
// per ascending move, S_END for the disk-end move, S_DN_RD/S_DN_OUT per descending move.
// Moves come out as one-cycle strobes on out_valid_o; the receiver cannot stall.
// Reset clears counts, flags, sequencer and configuration registers; list contents stay undefined.
`timescale 1ns / 1ps
`default_nettype none

module scan_disk_scheduler_unit
  import sdsch_pkg::*;
#(
  parameter int MAX_REQUESTS = SDSCH_MAX_REQ
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // command channel
  input  wire logic               start_i,
  output      logic               busy_o,
  input  wire logic [TRACK_W-1:0] track_i,
  input  wire logic               last_request_i,
  // result channel
  output      logic               out_valid_o,
  output      logic [TRACK_W-1:0] from_track_o,
  output      logic [TRACK_W-1:0] to_track_o,
  output      logic [TRACK_W-1:0] move_distance_o,
  output      logic [SEEK_W-1:0]  total_seek_o,
  output      logic               last_move_o,
  output      logic               dropped_o,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [APB_AW-1:0]  paddr,
  input  wire logic [APB_DW-1:0]  pwdata,
  output      logic [APB_DW-1:0]  prdata,
  output      logic               pready
);

  localparam int IDXW  = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CW    = $clog2(MAX_REQUESTS + 1);
  localparam int AW    = IDXW + 1;
  localparam int DEPTH = 2 * (2 ** IDXW);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_INS    = 8'b0000_0010,
    S_PUT    = 8'b0000_0100,
    S_UP_RD  = 8'b0000_1000,
    S_UP_OUT = 8'b0001_0000,
    S_END    = 8'b0010_0000,
    S_DN_RD  = 8'b0100_0000,
    S_DN_OUT = 8'b1000_0000
  } state_e;

  state_e             state_q, state_d;
  logic [TRACK_W-1:0] disk_end_q, start_head_q;
  logic [CW-1:0]      up_cnt_q, up_cnt_d, dn_cnt_q, dn_cnt_d;
  logic               ovf_q, ovf_d;
  logic [TRACK_W-1:0] val_q, val_d;
  logic               last_q, last_d;
  logic               sel_q, sel_d;
  logic [CW-1:0]      b_q, b_d;
  logic [CW-1:0]      idx_q, idx_d;
  logic [TRACK_W-1:0] pos_q, pos_d;

  logic               ov_q, ov_d;
  logic [TRACK_W-1:0] from_q, from_d, to_q, to_d, dist_q, dist_d;
  logic [SEEK_W-1:0]  seek_q, seek_d;
  logic               lmove_q, lmove_d, drop_q, drop_d;

  // RAM and shared unit hookup
  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [TRACK_W-1:0] ram_wdata, ram_rdata;
  logic [TRACK_W-1:0] alu_a, alu_b, alu_abs;
  logic               alu_lt;

  logic               accept, full, cfg_wr;
  logic [CW-1:0]      cnt_sel, idx_inc;
  logic [CW:0]        cnt_sum;
  logic [SEEK_W:0]    seek_sum;

  sdsch_ram #(
    .WIDTH (TRACK_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  sdsch_alu u_alu (
    .op_a_i (alu_a),
    .op_b_i (alu_b),
    .lt_o   (alu_lt),
    .abs_o  (alu_abs)
  );

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disk_end_q   <= DISK_END_RST;
      start_head_q <= START_HEAD_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_DISK_END:   disk_end_q   <= pwdata[TRACK_W-1:0];
        REG_START_HEAD: start_head_q <= pwdata[TRACK_W-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_DISK_END:   prdata = {{(APB_DW-TRACK_W){1'b0}}, disk_end_q};
      REG_START_HEAD: prdata = {{(APB_DW-TRACK_W){1'b0}}, start_head_q};
      default:        prdata = '0;
    endcase
  end

  // handshake and small helpers
  assign busy_o   = (state_q != S_IDLE);
  assign accept   = start_i & ~busy_o;
  assign cnt_sum  = {1'b0, up_cnt_q} + {1'b0, dn_cnt_q};
  assign full     = (cnt_sum >= (CW+1)'(MAX_REQUESTS));
  assign cnt_sel  = alu_lt ? up_cnt_q : dn_cnt_q;
  assign idx_inc  = idx_q + CW'(1);
  assign seek_sum = {1'b0, seek_q} + (SEEK_W+1)'(alu_abs);

  // shared unit operand select
  always_comb begin
    alu_a = pos_q;
    alu_b = ram_rdata;
    case (state_q)
      S_IDLE: begin
        alu_a = start_head_q;
        alu_b = track_i;
      end
      S_INS: begin
        // ascending list shifts on entry > v, descending on entry < v
        alu_a = (sel_q == LIST_UP) ? val_q : ram_rdata;
        alu_b = (sel_q == LIST_UP) ? ram_rdata : val_q;
      end
      S_END: alu_b = disk_end_q;
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    up_cnt_d = up_cnt_q;
    dn_cnt_d = dn_cnt_q;
    ovf_d    = ovf_q;
    val_d    = val_q;
    last_d   = last_q;
    sel_d    = sel_q;
    b_d      = b_q;
    idx_d    = idx_q;
    pos_d    = pos_q;
    seek_d   = seek_q;
    ov_d     = 1'b0;
    from_d   = from_q;
    to_d     = to_q;
    dist_d   = dist_q;
    lmove_d  = lmove_q;
    drop_d   = drop_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = val_q;
    ram_raddr = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          val_d  = track_i;
          last_d = last_request_i;
          sel_d  = alu_lt;
          b_d    = cnt_sel;
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            if (alu_lt) up_cnt_d = up_cnt_q + CW'(1);
            else        dn_cnt_d = dn_cnt_q + CW'(1);
          end
          if (!full && cnt_sel != '0) begin
            ram_raddr = {alu_lt, cnt_sel[IDXW-1:0] - IDXW'(1)};
            state_d   = S_INS;
          end else begin
            if (!full) begin
              ram_we    = 1'b1;
              ram_waddr = {alu_lt, IDXW'(0)};
              ram_wdata = track_i;
            end
            if (last_request_i) begin
              pos_d   = start_head_q;
              idx_d   = '0;
              seek_d  = '0;
              state_d = (up_cnt_d != '0) ? S_UP_RD : S_END;
            end
          end
        end
      end

      S_INS: begin
        ram_we = 1'b1;
        if (alu_lt) begin
          // move entry one place up, fetch the next lower one
          ram_waddr = {sel_q, b_q[IDXW-1:0]};
          ram_wdata = ram_rdata;
          b_d       = b_q - CW'(1);
          ram_raddr = {sel_q, b_d[IDXW-1:0] - IDXW'(1)};
          if (b_q == CW'(1)) state_d = S_PUT;
        end else begin
          ram_waddr = {sel_q, b_q[IDXW-1:0]};
          ram_wdata = val_q;
          if (last_q) begin
            pos_d   = start_head_q;
            idx_d   = '0;
            seek_d  = '0;
            state_d = (up_cnt_q != '0) ? S_UP_RD : S_END;
          end else begin
            state_d = S_IDLE;
          end
        end
      end

      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = {sel_q, IDXW'(0)};
        ram_wdata = val_q;
        if (last_q) begin
          pos_d   = start_head_q;
          idx_d   = '0;
          seek_d  = '0;
          state_d = (up_cnt_q != '0) ? S_UP_RD : S_END;
        end else begin
          state_d = S_IDLE;
        end
      end

      S_UP_RD: begin
        ram_raddr = {LIST_UP, idx_q[IDXW-1:0]};
        state_d   = S_UP_OUT;
      end

      S_UP_OUT: begin
        ov_d    = 1'b1;
        to_d    = ram_rdata;
        lmove_d = 1'b0;
        pos_d   = ram_rdata;
        if (idx_inc == up_cnt_q) begin
          idx_d   = '0;
          state_d = S_END;
        end else begin
          idx_d   = idx_inc;
          state_d = S_UP_RD;
        end
      end

      S_END: begin
        ov_d    = 1'b1;
        to_d    = disk_end_q;
        lmove_d = (dn_cnt_q == '0);
        pos_d   = disk_end_q;
        idx_d   = '0;
        state_d = (dn_cnt_q == '0) ? S_IDLE : S_DN_RD;
      end

      S_DN_RD: begin
        ram_raddr = {LIST_DN, idx_q[IDXW-1:0]};
        state_d   = S_DN_OUT;
      end

      S_DN_OUT: begin
        ov_d    = 1'b1;
        to_d    = ram_rdata;
        lmove_d = (idx_inc == dn_cnt_q);
        pos_d   = ram_rdata;
        idx_d   = idx_inc;
        state_d = (idx_inc == dn_cnt_q) ? S_IDLE : S_DN_RD;
      end

      default: state_d = S_IDLE;
    endcase

    // common move result; end of schedule clears the batch
    if (ov_d) begin
      from_d = pos_q;
      dist_d = alu_abs;
      seek_d = seek_sum[SEEK_W] ? {SEEK_W{1'b1}} : seek_sum[SEEK_W-1:0];
      drop_d = ovf_q;
      if (lmove_d) begin
        up_cnt_d = '0;
        dn_cnt_d = '0;
        ovf_d    = 1'b0;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      up_cnt_q <= '0;
      dn_cnt_q <= '0;
      ovf_q    <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      up_cnt_q <= up_cnt_d;
      dn_cnt_q <= dn_cnt_d;
      ovf_q    <= ovf_d;
      ov_q     <= ov_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    val_q   <= val_d;
    last_q  <= last_d;
    sel_q   <= sel_d;
    b_q     <= b_d;
    idx_q   <= idx_d;
    pos_q   <= pos_d;
    seek_q  <= seek_d;
    from_q  <= from_d;
    to_q    <= to_d;
    dist_q  <= dist_d;
    lmove_q <= lmove_d;
    drop_q  <= drop_d;
  end

  assign out_valid_o     = ov_q;
  assign from_track_o    = from_q;
  assign to_track_o      = to_q;
  assign move_distance_o = dist_q;
  assign total_seek_o    = seek_q;
  assign last_move_o     = lmove_q;
  assign dropped_o       = drop_q;

endmodule

`default_nettype wire

FILE: rtl/sdsch_checker.sv
// Port-level checker for scan_disk_scheduler_unit, bound to the top level.
// Depends on sdsch_pkg (field widths).
`timescale 1ns / 1ps
`default_nettype none

module sdsch_checker
  import sdsch_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               start_i,
  input wire logic               busy_o,
  input wire logic               last_request_i,
  input wire logic               out_valid_o,
  input wire logic [TRACK_W-1:0] from_track_o,
  input wire logic [TRACK_W-1:0] to_track_o,
  input wire logic [TRACK_W-1:0] move_distance_o,
  input wire logic               last_move_o
);

  // a last request always starts a schedule
  a_last_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && last_request_i |=> busy_o)
    else $error("last request did not start scheduling");

  // more moves follow a non-final beat; the final one may show with busy already low
  a_more_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_move_o |=> busy_o || out_valid_o)
    else $error("schedule ended without a final move");

  // nothing follows the final beat directly
  a_final_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_move_o |=> !out_valid_o)
    else $error("beat right after final move");

  // distance matches the endpoints
  a_distance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> move_distance_o == ((to_track_o > from_track_o) ?
                    (to_track_o - from_track_o) : (from_track_o - to_track_o)))
    else $error("move distance mismatch");

endmodule

bind scan_disk_scheduler_unit sdsch_checker u_sdsch_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .busy_o          (busy_o),
  .last_request_i  (last_request_i),
  .out_valid_o     (out_valid_o),
  .from_track_o    (from_track_o),
  .to_track_o      (to_track_o),
  .move_distance_o (move_distance_o),
  .last_move_o     (last_move_o)
);

`default_nettype wire

FILE: tb/sdsch_schedule_checker.sv
`timescale 1ns / 1ps
// Checker for the SCAN disk scheduler. It mirrors the two registers, builds the
// expected seek schedule for each batch and compares every move beat.
// Depends on sdsch_pkg only.
module sdsch_schedule_checker
  import sdsch_pkg::*;
#(
  parameter int MAX_REQUESTS = SDSCH_MAX_REQ
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // command channel
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [TRACK_W-1:0] track_i,
  input  logic               last_request_i,
  // move channel
  input  logic               out_valid_i,
  input  logic [TRACK_W-1:0] from_track_i,
  input  logic [TRACK_W-1:0] to_track_i,
  input  logic [TRACK_W-1:0] move_distance_i,
  input  logic [SEEK_W-1:0]  total_seek_i,
  input  logic               last_move_i,
  input  logic               dropped_i,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  input  logic               pready,
  // status to the testbench top
  output int                 mismatch_count_o,
  output int                 pending_o
);

  localparam int SEEK_LIMIT = (1 << SEEK_W) - 1;

  typedef struct packed {
    logic [TRACK_W-1:0] from_trk;
    logic [TRACK_W-1:0] to_trk;
    logic [TRACK_W-1:0] move_dist;
    logic [SEEK_W-1:0]  seek_total;
    logic               last_mv;
    logic               drop;
  } move_t;

  // register mirror
  logic [TRACK_W-1:0] disk_end_q;
  logic [TRACK_W-1:0] start_head_q;

  // batch state: both lists are kept sorted as requests arrive
  logic [TRACK_W-1:0] up_trk [MAX_REQUESTS];
  logic [TRACK_W-1:0] dn_trk [MAX_REQUESTS];
  int                 up_cnt;
  int                 dn_cnt;
  logic               ovf_seen;
  int                 seek_acc;

  move_t              sched_q [$];

  // one expected move, running total saturates
  task automatic queue_move(input logic [TRACK_W-1:0] from_t, input logic [TRACK_W-1:0] to_t,
                            input logic last_mv);
    move_t m;
    int    span;
    span = (to_t > from_t) ? int'(to_t) - int'(from_t) : int'(from_t) - int'(to_t);
    seek_acc = seek_acc + span;
    if (seek_acc > SEEK_LIMIT) seek_acc = SEEK_LIMIT;
    m.from_trk   = from_t;
    m.to_trk     = to_t;
    m.move_dist  = span[TRACK_W-1:0];
    m.seek_total = seek_acc[SEEK_W-1:0];
    m.last_mv    = last_mv;
    m.drop       = ovf_seen;
    sched_q.push_back(m);
  endtask

  // store one request; on the last one lay out the whole sweep
  task automatic take_request(input logic [TRACK_W-1:0] trk, input logic last_req);
    int                 j;
    int                 k;
    int                 n_moves;
    logic [TRACK_W-1:0] pos;
    if (up_cnt + dn_cnt >= MAX_REQUESTS) begin
      ovf_seen = 1'b1;
    end else if (trk > start_head_q) begin
      j = up_cnt;
      while (j > 0 && up_trk[j-1] > trk) begin
        up_trk[j] = up_trk[j-1];
        j--;
      end
      up_trk[j] = trk;
      up_cnt++;
    end else begin
      j = dn_cnt;
      while (j > 0 && dn_trk[j-1] < trk) begin
        dn_trk[j] = dn_trk[j-1];
        j--;
      end
      dn_trk[j] = trk;
      dn_cnt++;
    end

    if (last_req) begin
      n_moves  = up_cnt + dn_cnt + 1;
      seek_acc = 0;
      pos      = start_head_q;
      k        = 0;
      for (j = 0; j < up_cnt; j++) begin
        k++;
        queue_move(pos, up_trk[j], k == n_moves);
        pos = up_trk[j];
      end
      k++;
      queue_move(pos, disk_end_q, k == n_moves);
      pos = disk_end_q;
      for (j = 0; j < dn_cnt; j++) begin
        k++;
        queue_move(pos, dn_trk[j], k == n_moves);
        pos = dn_trk[j];
      end
      up_cnt   = 0;
      dn_cnt   = 0;
      ovf_seen = 1'b0;
    end
  endtask

  // compare one move beat against the oldest expectation
  task automatic check_move(input move_t got);
    move_t want;
    if (sched_q.size() == 0) begin
      mismatch_count_o++;
      if (mismatch_count_o <= 10)
        $display("%0t: unexpected move from=%0d to=%0d dist=%0d seek=%0d last=%0b drop=%0b",
                 $realtime, got.from_trk, got.to_trk, got.move_dist, got.seek_total,
                 got.last_mv, got.drop);
    end else begin
      want = sched_q.pop_front();
      if (got.from_trk !== want.from_trk || got.to_trk !== want.to_trk ||
          got.move_dist !== want.move_dist || got.seek_total !== want.seek_total ||
          got.last_mv !== want.last_mv || got.drop !== want.drop) begin
        mismatch_count_o++;
        if (mismatch_count_o <= 10) begin
          $display("%0t: move mismatch", $realtime);
          $display("  exp from=%0d to=%0d dist=%0d seek=%0d last=%0b drop=%0b",
                   want.from_trk, want.to_trk, want.move_dist, want.seek_total,
                   want.last_mv, want.drop);
          $display("  got from=%0d to=%0d dist=%0d seek=%0d last=%0b drop=%0b",
                   got.from_trk, got.to_trk, got.move_dist, got.seek_total,
                   got.last_mv, got.drop);
        end
      end
    end
  endtask

  // moves are checked before the request of the same edge is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disk_end_q       = DISK_END_RST;
      start_head_q     = START_HEAD_RST;
      up_cnt           = 0;
      dn_cnt           = 0;
      ovf_seen         = 1'b0;
      seek_acc         = 0;
      mismatch_count_o = 0;
      sched_q.delete();
    end else begin
      if (out_valid_i)
        check_move({from_track_i, to_track_i, move_distance_i, total_seek_i,
                    last_move_i, dropped_i});
      if (start_i && !busy_i)
        take_request(track_i, last_request_i);
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_DISK_END)
          disk_end_q = pwdata[TRACK_W-1:0];
        else
          start_head_q = pwdata[TRACK_W-1:0];
      end
    end
    pending_o = sched_q.size();
  end

endmodule

FILE: tb/tb_scan_disk_scheduler_unit.sv
`timescale 1ns / 1ps
// Testbench top for scan_disk_scheduler_unit: clock, reset, request and register
// stimulus, and the verdict. Needs sdsch_pkg, the block and sdsch_schedule_checker.
module tb_scan_disk_scheduler_unit
  import sdsch_pkg::*;
;

  localparam int MAX_REQ      = SDSCH_MAX_REQ;
  localparam int DRAIN_CYCLES = 2 * MAX_REQ + 12;
  localparam int RAND_ITEMS   = 460;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [TRACK_W-1:0] track;
  logic               last_req;
  logic               mv_valid;
  logic [TRACK_W-1:0] mv_from;
  logic [TRACK_W-1:0] mv_to;
  logic [TRACK_W-1:0] mv_dist;
  logic [SEEK_W-1:0]  mv_seek;
  logic               mv_last;
  logic               mv_drop;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [APB_AW-1:0]  paddr;
  logic [APB_DW-1:0]  pwdata;
  logic [APB_DW-1:0]  prdata;
  logic               pready;

  int                 fail_cnt;
  int                 open_moves;
  int                 idle_pct;
  logic [TRACK_W-1:0] cur_head;
  logic [TRACK_W-1:0] cur_disk_end;

  scan_disk_scheduler_unit #(
    .MAX_REQUESTS(MAX_REQ)
  ) u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_o         (busy),
    .track_i        (track),
    .last_request_i (last_req),
    .out_valid_o    (mv_valid),
    .from_track_o   (mv_from),
    .to_track_o     (mv_to),
    .move_distance_o(mv_dist),
    .total_seek_o   (mv_seek),
    .last_move_o    (mv_last),
    .dropped_o      (mv_drop),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  sdsch_schedule_checker #(
    .MAX_REQUESTS(MAX_REQ)
  ) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .start_i         (start),
    .busy_i          (busy),
    .track_i         (track),
    .last_request_i  (last_req),
    .out_valid_i     (mv_valid),
    .from_track_i    (mv_from),
    .to_track_i      (mv_to),
    .move_distance_i (mv_dist),
    .total_seek_i    (mv_seek),
    .last_move_i     (mv_last),
    .dropped_i       (mv_drop),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .mismatch_count_o(fail_cnt),
    .pending_o       (open_moves)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("scan_disk_scheduler_unit test failed");
    $finish;
  end

  // one request beat; each cycle in front of it idles at random
  task automatic drive_request(input logic [TRACK_W-1:0] trk, input logic last_in);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start    = 1'b1;
    track    = trk;
    last_req = last_in;
    do @(posedge clk); while (busy);
  endtask

  // drop start, wait for all moves, let any insertion finish
  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    while (open_moves != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  // setup + access phase, block must be idle
  task automatic write_reg(input logic idx, input logic [TRACK_W-1:0] val);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = {{(APB_DW-TRACK_W){1'b0}}, val};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    if (idx == REG_DISK_END) cur_disk_end = val;
    else cur_head = val;
  endtask

  task automatic set_geometry(input logic [TRACK_W-1:0] end_trk,
                              input logic [TRACK_W-1:0] head_trk);
    settle();
    write_reg(REG_DISK_END, end_trk);
    write_reg(REG_START_HEAD, head_trk);
  endtask

  initial begin
    int                 batch_no;
    int                 batch_len;
    int                 rand_items;
    int                 sel;
    int                 t;
    logic [TRACK_W-1:0] trk;

    rst_n        = 1'b0;
    start        = 1'b0;
    track        = '0;
    last_req     = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    idle_pct     = 37;
    cur_head     = START_HEAD_RST;
    cur_disk_end = DISK_END_RST;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset geometry, lone request equal to the head goes down
    drive_request(16'd0, 1'b1);

    // full span, both track extremes
    set_geometry(16'hFFFF, 16'h0000);
    drive_request(16'hFFFF, 1'b0);
    drive_request(16'h0000, 1'b0);
    drive_request(16'h0001, 1'b0);
    drive_request(16'h8000, 1'b1);

    // head at top, disk end at zero: long moves, seek total saturates
    set_geometry(16'h0000, 16'hFFFF);
    drive_request(16'hFFFF, 1'b0);
    drive_request(16'h0000, 1'b0);
    drive_request(16'hAAAA, 1'b1);

    // requests past the disk end, head walks backwards
    set_geometry(16'd100, 16'd50);
    drive_request(16'd200, 1'b0);
    drive_request(16'd10, 1'b0);
    drive_request(16'd60, 1'b0);
    drive_request(16'd50, 1'b0);
    drive_request(16'd5000, 1'b1);

    // registers change in the middle of a batch
    set_geometry(16'd2000, 16'd1000);
    drive_request(16'd500, 1'b0);
    drive_request(16'd1500, 1'b0);
    settle();
    write_reg(REG_START_HEAD, 16'd400);
    write_reg(REG_DISK_END, 16'd3000);
    drive_request(16'd450, 1'b0);
    drive_request(16'd300, 1'b1);

    // back to reset geometry, repeated tracks
    set_geometry(DISK_END_RST, START_HEAD_RST);
    drive_request(16'd7, 1'b0);
    drive_request(16'd7, 1'b0);
    drive_request(16'd7, 1'b1);

    // random batches; a stretch in the middle runs without gaps
    rand_items = 0;
    batch_no   = 0;
    while (rand_items < RAND_ITEMS) begin
      idle_pct = (batch_no >= 8 && batch_no < 16) ? 0 : 37;
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 3))
          0: set_geometry(TRACK_W'($urandom), TRACK_W'($urandom));
          1: set_geometry(16'hFFFF, TRACK_W'($urandom_range(0, 2000)));
          2: set_geometry(TRACK_W'($urandom_range(0, 500)), TRACK_W'($urandom));
          default: set_geometry($urandom_range(0, 1) ? 16'hFFFF : 16'h0000,
                                $urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
        endcase
      end

      // mostly short batches, some full, some past capacity
      sel = $urandom_range(0, 99);
      if (sel < 65) batch_len = $urandom_range(1, 8);
      else if (sel < 85) batch_len = $urandom_range(9, MAX_REQ - 1);
      else if (sel < 95) batch_len = $urandom_range(MAX_REQ, MAX_REQ + 2);
      else batch_len = $urandom_range(MAX_REQ + 3, MAX_REQ + 8);

      for (int i = 1; i <= batch_len; i++) begin
        case ($urandom_range(0, 9))
          0: trk = cur_head;
          1: trk = 16'h0000;
          2: trk = 16'hFFFF;
          3, 4: begin
            t = int'(cur_head) + int'($urandom_range(1, 64));
            trk = (t > 65535) ? 16'hFFFF : t[TRACK_W-1:0];
          end
          5: begin
            t = int'(cur_head) - int'($urandom_range(0, 64));
            trk = (t < 0) ? 16'h0000 : t[TRACK_W-1:0];
          end
          6: begin
            t = int'(cur_disk_end) + int'($urandom_range(0, 3)) - 1;
            trk = (t < 0) ? 16'h0000 : (t > 65535) ? 16'hFFFF : t[TRACK_W-1:0];
          end
          default: trk = TRACK_W'($urandom);
        endcase
        drive_request(trk, i == batch_len);
        rand_items++;
      end
      batch_no++;
    end

    settle();
    if (fail_cnt == 0 && open_moves == 0) begin
      $display("scan_disk_scheduler_unit test passed");
    end else begin
      $display("scan_disk_scheduler_unit test failed");
    end
    $finish;
  end

endmodule
